// ===== design/gcw_pkg.sv =====
// ---------------------------------------------------------------------------
// gcw_pkg
// Shared types, constants and the 5x7 font for the GLCD text character writer.
// ---------------------------------------------------------------------------
package gcw_pkg;

  localparam int TEXT_ROWS_DEF = 8;
  localparam int CFG_ADDR_W    = 4;
  localparam int CFG_DATA_W    = 32;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam int CELLS_PER_ROW = 20;
  localparam int HALF_CELLS    = 10;
  localparam int CELL_WIDTH    = 6;
  localparam int LEFT_OFFSET   = 4;

  localparam logic [7:0] PAGE_CMD   = 8'hB8;
  localparam logic [7:0] COL_CMD    = 8'h40;
  localparam logic [7:0] CURSOR_BIT = 8'h80;
  localparam logic [7:0] BLANK_BYTE = 8'h00;

  localparam logic [1:0] CS_LEFT  = 2'b01;
  localparam logic [1:0] CS_RIGHT = 2'b10;
  localparam logic [1:0] CS_BOTH  = 2'b11;

  typedef enum logic {
    KIND_SET_POS = 1'b0,
    KIND_CHAR    = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    REG_CURSOR_ENABLE = 2'd0,
    REG_CURSOR_ROW    = 2'd1,
    REG_CURSOR_COLUMN = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    kind_e      kind;
    logic [2:0] row;
    logic [4:0] column;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic [1:0] chip_select;
    logic       is_data;
    logic [7:0] bus_byte;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic       cursor_enable;
    logic [2:0] cursor_row;
    logic [4:0] cursor_column;
  } cfg_t;

  typedef logic [0:4][7:0] glyph_t;

  typedef struct packed {
    logic       is_char;
    logic [1:0] chip_select;
    logic [7:0] page_cmd;
    logic [7:0] col_cmd;
    glyph_t     glyph;
  } cmd_t;

  function automatic glyph_t font_glyph(input logic [7:0] code);
    glyph_t g;
    unique case (code)
      8'h20: g = 40'h00_00_00_00_00;
      8'h21: g = 40'h00_00_4f_00_00;
      8'h22: g = 40'h00_07_00_07_00;
      8'h23: g = 40'h14_7f_14_7f_14;
      8'h24: g = 40'h24_2a_7f_2a_12;
      8'h25: g = 40'h23_13_08_64_62;
      8'h26: g = 40'h36_49_55_22_50;
      8'h27: g = 40'h00_05_03_00_00;
      8'h28: g = 40'h00_1c_22_41_00;
      8'h29: g = 40'h00_41_22_1c_00;
      8'h2a: g = 40'h14_08_3e_08_14;
      8'h2b: g = 40'h08_08_3e_08_08;
      8'h2c: g = 40'h00_50_30_00_00;
      8'h2d: g = 40'h08_08_08_08_08;
      8'h2e: g = 40'h00_60_60_00_00;
      8'h2f: g = 40'h20_10_08_04_02;
      8'h30: g = 40'h3e_51_49_45_3e;
      8'h31: g = 40'h00_42_7f_40_00;
      8'h32: g = 40'h42_61_51_49_46;
      8'h33: g = 40'h21_41_45_4b_31;
      8'h34: g = 40'h18_14_12_7f_10;
      8'h35: g = 40'h27_45_45_45_39;
      8'h36: g = 40'h3c_4a_49_49_30;
      8'h37: g = 40'h01_71_09_05_03;
      8'h38: g = 40'h36_49_49_49_36;
      8'h39: g = 40'h06_49_49_29_1e;
      8'h3a: g = 40'h00_36_36_00_00;
      8'h3b: g = 40'h00_56_36_00_00;
      8'h3c: g = 40'h08_14_22_41_00;
      8'h3d: g = 40'h14_14_14_14_14;
      8'h3e: g = 40'h00_41_22_14_08;
      8'h3f: g = 40'h02_01_51_09_06;
      8'h40: g = 40'h32_49_79_41_3e;
      8'h41: g = 40'h7e_11_11_11_7e;
      8'h42: g = 40'h7f_49_49_49_36;
      8'h43: g = 40'h3e_41_41_41_22;
      8'h44: g = 40'h7f_41_41_22_1c;
      8'h45: g = 40'h7f_49_49_49_41;
      8'h46: g = 40'h7f_09_09_09_01;
      8'h47: g = 40'h3e_41_49_49_7a;
      8'h48: g = 40'h7f_08_08_08_7f;
      8'h49: g = 40'h00_41_7f_41_00;
      8'h4a: g = 40'h20_40_41_3f_01;
      8'h4b: g = 40'h7f_08_14_22_41;
      8'h4c: g = 40'h7f_40_40_40_40;
      8'h4d: g = 40'h7f_02_0c_02_7f;
      8'h4e: g = 40'h7f_04_08_10_7f;
      8'h4f: g = 40'h3e_41_41_41_3e;
      8'h50: g = 40'h7f_09_09_09_06;
      8'h51: g = 40'h3e_41_51_21_5e;
      8'h52: g = 40'h7f_09_19_29_46;
      8'h53: g = 40'h26_49_49_49_32;
      8'h54: g = 40'h01_01_7f_01_01;
      8'h55: g = 40'h3f_40_40_40_3f;
      8'h56: g = 40'h1f_20_40_20_1f;
      8'h57: g = 40'h3f_40_38_40_3f;
      8'h58: g = 40'h63_14_08_14_63;
      8'h59: g = 40'h07_08_70_08_07;
      8'h5a: g = 40'h61_51_49_45_43;
      8'h5b: g = 40'h00_7f_41_41_00;
      8'h5c: g = 40'h02_04_08_10_20;
      8'h5d: g = 40'h00_41_41_7f_00;
      8'h5e: g = 40'h04_02_01_02_04;
      8'h5f: g = 40'h40_40_40_40_40;
      8'h60: g = 40'h00_01_02_04_00;
      8'h61: g = 40'h20_54_54_54_78;
      8'h62: g = 40'h7f_48_44_44_38;
      8'h63: g = 40'h38_44_44_44_20;
      8'h64: g = 40'h38_44_44_48_7f;
      8'h65: g = 40'h38_54_54_54_18;
      8'h66: g = 40'h08_7e_09_01_02;
      8'h67: g = 40'h0c_52_52_52_3e;
      8'h68: g = 40'h7f_08_04_04_78;
      8'h69: g = 40'h00_04_7d_00_00;
      8'h6a: g = 40'h20_40_44_3d_00;
      8'h6b: g = 40'h7f_10_28_44_00;
      8'h6c: g = 40'h00_41_7f_40_00;
      8'h6d: g = 40'h7c_04_18_04_7c;
      8'h6e: g = 40'h7c_08_04_04_78;
      8'h6f: g = 40'h38_44_44_44_38;
      8'h70: g = 40'h7c_14_14_14_08;
      8'h71: g = 40'h08_14_14_18_7c;
      8'h72: g = 40'h7c_08_04_04_08;
      8'h73: g = 40'h48_54_54_54_20;
      8'h74: g = 40'h04_3f_44_40_20;
      8'h75: g = 40'h3c_40_40_20_7c;
      8'h76: g = 40'h1c_20_40_20_1c;
      8'h77: g = 40'h3c_40_30_40_3c;
      8'h78: g = 40'h44_28_10_28_44;
      8'h79: g = 40'h0c_50_50_50_3c;
      8'h7a: g = 40'h44_64_54_4c_44;
      8'h7b: g = 40'h00_08_36_41_00;
      8'h7c: g = 40'h00_00_77_00_00;
      8'h7d: g = 40'h00_41_36_08_00;
      8'h7e: g = 40'h08_04_08_10_08;
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

// ===== design/gcw_front.sv =====
// ---------------------------------------------------------------------------
// gcw_front
// Accepts items, tracks the text position and builds one command per item.
// ---------------------------------------------------------------------------
module gcw_front #(
  parameter int TEXT_ROWS = gcw_pkg::TEXT_ROWS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  gcw_pkg::in_item_t in_item_i,
  input  gcw_pkg::cfg_t    cfg_i,
  input  logic             q_full_i,
  output logic             push_o,
  output gcw_pkg::cmd_t    cmd_o
);

  logic [2:0] row_q, row_d;
  logic [4:0] col_q, col_d;
  logic [2:0] cur_row;
  logic [4:0] cur_col;
  logic [2:0] set_row;
  logic [4:0] set_col;
  logic       is_char;
  logic       mark;
  logic       left;
  logic [7:0] cell_x;

  function automatic logic [2:0] row_wrap(input logic [2:0] r);
    logic [3:0] m;
    m = {1'b0, r};
    for (int i = 0; i < 8; i++) begin
      if (m >= 4'(TEXT_ROWS)) begin
        m = m - 4'(TEXT_ROWS);
      end
    end
    return m[2:0];
  endfunction

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && in_ready_o;
  assign is_char    = (in_item_i.kind == gcw_pkg::KIND_CHAR);

  always_comb begin
    set_row = row_wrap(in_item_i.row);
    if (in_item_i.column >= 5'(gcw_pkg::CELLS_PER_ROW)) begin
      set_col = in_item_i.column - 5'(gcw_pkg::CELLS_PER_ROW);
    end else begin
      set_col = in_item_i.column;
    end
    cur_row = is_char ? row_q : set_row;
    cur_col = is_char ? col_q : set_col;
  end

  always_comb begin
    left = (cur_col < 5'(gcw_pkg::HALF_CELLS));
    if (left) begin
      cell_x = 8'(cur_col) * 8'(gcw_pkg::CELL_WIDTH) + 8'(gcw_pkg::LEFT_OFFSET);
    end else begin
      cell_x = 8'(cur_col - 5'(gcw_pkg::HALF_CELLS)) * 8'(gcw_pkg::CELL_WIDTH);
    end
    mark = cfg_i.cursor_enable && (cfg_i.cursor_row == cur_row) &&
           (cfg_i.cursor_column == cur_col);
    cmd_o.is_char     = is_char;
    cmd_o.chip_select = left ? gcw_pkg::CS_LEFT : gcw_pkg::CS_RIGHT;
    cmd_o.page_cmd    = gcw_pkg::PAGE_CMD + 8'(cur_row);
    cmd_o.col_cmd     = gcw_pkg::COL_CMD + cell_x;
    cmd_o.glyph       = gcw_pkg::font_glyph(in_item_i.char_code);
    for (int i = 0; i < 5; i++) begin
      cmd_o.glyph[i] = cmd_o.glyph[i] | (mark ? gcw_pkg::CURSOR_BIT : 8'h00);
    end
  end

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (push_o) begin
      if (!is_char) begin
        row_d = set_row;
        col_d = set_col;
      end else if (col_q == 5'(gcw_pkg::CELLS_PER_ROW - 1)) begin
        col_d = '0;
        row_d = (row_q == 3'(TEXT_ROWS - 1)) ? 3'd0 : row_q + 3'd1;
      end else begin
        col_d = col_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

endmodule

// ===== design/gcw_queue.sv =====
// ---------------------------------------------------------------------------
// gcw_queue
// Short command queue between the front and the back.
// ---------------------------------------------------------------------------
module gcw_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  gcw_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output gcw_pkg::cmd_t cmd_o
);

  gcw_pkg::cmd_t                 mem_q [gcw_pkg::QUEUE_DEPTH];
  logic [gcw_pkg::QPTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [gcw_pkg::QPTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [gcw_pkg::QCNT_W-1:0]    count_q, count_d;
  logic                          do_push;
  logic                          do_pop;

  function automatic logic [gcw_pkg::QPTR_W-1:0] ptr_next(
    input logic [gcw_pkg::QPTR_W-1:0] p
  );
    return (p == gcw_pkg::QPTR_W'(gcw_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (count_q == gcw_pkg::QCNT_W'(gcw_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? ptr_next(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== design/gcw_back.sv =====
// ---------------------------------------------------------------------------
// gcw_back
// Steps through the bus writes of the command at the head of the queue.
// ---------------------------------------------------------------------------
module gcw_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  gcw_pkg::cmd_t      cmd_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output gcw_pkg::out_item_t out_item_o
);

  localparam logic [2:0] STEP_PAGE        = 3'd0;
  localparam logic [2:0] STEP_COLUMN      = 3'd1;
  localparam logic [2:0] STEP_FIRST_GLYPH = 3'd2;
  localparam logic [2:0] STEP_BLANK       = 3'd7;

  logic [2:0]         step_q, step_d;
  logic               out_valid_q, out_valid_d;
  gcw_pkg::out_item_t out_item_q;
  gcw_pkg::out_item_t write_item;
  logic               advance;
  logic               last_step;
  logic [2:0]         glyph_idx;

  assign advance   = q_valid_i && (!out_valid_q || out_ready_i);
  assign last_step = (step_q == STEP_BLANK) || (step_q == STEP_COLUMN && !cmd_i.is_char);
  assign pop_o     = advance && last_step;
  assign glyph_idx = 3'(step_q - STEP_FIRST_GLYPH);

  always_comb begin
    write_item.chip_select = cmd_i.chip_select;
    write_item.is_data     = 1'b1;
    write_item.bus_byte    = gcw_pkg::BLANK_BYTE;
    write_item.last        = 1'b0;
    case (step_q)
      STEP_PAGE: begin
        write_item.chip_select = gcw_pkg::CS_BOTH;
        write_item.is_data     = 1'b0;
        write_item.bus_byte    = cmd_i.page_cmd;
      end
      STEP_COLUMN: begin
        write_item.is_data  = 1'b0;
        write_item.bus_byte = cmd_i.col_cmd;
        write_item.last     = !cmd_i.is_char;
      end
      STEP_BLANK: begin
        write_item.last = 1'b1;
      end
      default: begin
        write_item.bus_byte = cmd_i.glyph[glyph_idx];
      end
    endcase
  end

  always_comb begin
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (advance) begin
      step_d      = last_step ? STEP_PAGE : step_q + 3'd1;
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_PAGE;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= write_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== design/glcd_text_character_writer.sv =====
// ---------------------------------------------------------------------------
// glcd_text_character_writer
// Turns text items into bus writes for a two-controller 128x64 graphic LCD.
// ---------------------------------------------------------------------------
// The input channel takes one item per handshake: a set-position item or a
// character item. The output channel gives one bus write per handshake.
// A set-position item yields two writes (page and column commands); a
// character item yields eight (two commands, five font columns, one blank).
// The first write of an item is valid on the output after the item passes
// through the command queue and the output register, and writes then follow
// one per cycle while the receiver takes them. The output register drains one
// write per cycle while the receiver is ready. A two-entry command queue sits
// between the input side and the write sequencer, so new items are accepted
// while earlier ones are still being written out. When the receiver stalls,
// the current write holds and the queue fills; input ready drops only when
// the queue is full. Reset clears the text position, the cursor registers,
// the queue and the output valid. The user must write the cursor registers
// over the APB port only while the block is idle; it does not enforce this.
// ---------------------------------------------------------------------------
module glcd_text_character_writer #(
  parameter int TEXT_ROWS = gcw_pkg::TEXT_ROWS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  gcw_pkg::in_item_t              in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output gcw_pkg::out_item_t             out_item_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [gcw_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [gcw_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [gcw_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);

  gcw_pkg::cfg_t     cfg_q, cfg_d;
  gcw_pkg::cfg_reg_e reg_sel;
  gcw_pkg::cmd_t     front_cmd;
  gcw_pkg::cmd_t     head_cmd;
  logic              cfg_write;
  logic              q_full;
  logic              q_valid;
  logic              push;
  logic              pop;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_sel   = gcw_pkg::cfg_reg_e'(paddr[gcw_pkg::CFG_ADDR_W-1:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_write) begin
      unique case (reg_sel)
        gcw_pkg::REG_CURSOR_ENABLE: cfg_d.cursor_enable = pwdata[0];
        gcw_pkg::REG_CURSOR_ROW:    cfg_d.cursor_row    = pwdata[2:0];
        gcw_pkg::REG_CURSOR_COLUMN: cfg_d.cursor_column = pwdata[4:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      gcw_pkg::REG_CURSOR_ENABLE: prdata = gcw_pkg::CFG_DATA_W'(cfg_q.cursor_enable);
      gcw_pkg::REG_CURSOR_ROW:    prdata = gcw_pkg::CFG_DATA_W'(cfg_q.cursor_row);
      gcw_pkg::REG_CURSOR_COLUMN: prdata = gcw_pkg::CFG_DATA_W'(cfg_q.cursor_column);
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  gcw_front #(
    .TEXT_ROWS(TEXT_ROWS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .cfg_i      (cfg_q),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (front_cmd)
  );

  gcw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (head_cmd)
  );

  gcw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== design/gcw_checker.sv =====
// ---------------------------------------------------------------------------
// gcw_checker
// Port-level checks on the bus writes of the GLCD text character writer.
// ---------------------------------------------------------------------------
module gcw_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input gcw_pkg::out_item_t out_item_o
);

  logic page_taken;

  assign page_taken = out_valid_o && out_ready_i &&
                      (out_item_o.chip_select == gcw_pkg::CS_BOTH);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("Output item changed while stalled.");

  a_page_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.chip_select == gcw_pkg::CS_BOTH) |->
      !out_item_o.is_data && !out_item_o.last &&
      (out_item_o.bus_byte[7:3] == gcw_pkg::PAGE_CMD[7:3]))
    else $error("Page command malformed.");

  a_column_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    page_taken |=> out_valid_o && !out_item_o.is_data &&
      (out_item_o.chip_select == gcw_pkg::CS_LEFT ||
       out_item_o.chip_select == gcw_pkg::CS_RIGHT))
    else $error("Page command not followed by a column command.");

  a_data_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.is_data |->
      (out_item_o.chip_select == gcw_pkg::CS_LEFT ||
       out_item_o.chip_select == gcw_pkg::CS_RIGHT))
    else $error("Display data sent to both controllers.");

  a_blank_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.is_data && out_item_o.last |->
      (out_item_o.bus_byte == gcw_pkg::BLANK_BYTE))
    else $error("Final data write of a character is not blank.");

endmodule

bind glcd_text_character_writer gcw_checker u_gcw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);
